@@ hw/rtl/oaht_pkg.sv @@
// ----------------------------------------------------------------------------
// oaht_pkg: shared types and constants
// Command, status and slot codes, the prime and reciprocal tables, and the
// controller links.
// ----------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

  localparam int SHIFT_W   = 4;
  localparam int COUNT_W   = 11;
  localparam int MIN_SHIFT = 3;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] SLOT_UNUSED = 2'd0;
  localparam logic [1:0] SLOT_TOMB   = 2'd1;
  localparam logic [1:0] SLOT_LIVE   = 2'd2;

  typedef struct packed {
    logic [1:0]  state;
    logic [31:0] key;
    logic [31:0] value;
  } slot_t;

  typedef struct packed {
    logic load;
    logic sweep_init;
    logic sweep_adv;
    logic div_start;
    logic div_step;
    logic probe_init;
    logic probe_eval;
    logic probe_adv;
    logic eval_end;
    logic fin;
  } ctl_t;

  typedef struct packed {
    logic new_clear;
    logic div_last;
    logic slot_unused;
    logic slot_match;
    logic probe_last;
    logic sweep_last;
    logic out_free;
  } sts_t;

  function automatic logic [16:0] prime_of(input logic [4:0] s);
    logic [16:0] p;
    case (s)
      5'd0:    p = 17'd1;
      5'd1:    p = 17'd2;
      5'd2:    p = 17'd3;
      5'd3:    p = 17'd7;
      5'd4:    p = 17'd13;
      5'd5:    p = 17'd31;
      5'd6:    p = 17'd61;
      5'd7:    p = 17'd127;
      5'd8:    p = 17'd251;
      5'd9:    p = 17'd509;
      5'd10:   p = 17'd1021;
      5'd11:   p = 17'd2039;
      5'd12:   p = 17'd4093;
      5'd13:   p = 17'd8191;
      5'd14:   p = 17'd16381;
      5'd15:   p = 17'd32749;
      5'd16:   p = 17'd65521;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

  // floor(2^48 / prime); the quotient estimate is at most one below the true one
  function automatic logic [47:0] recip_of(input logic [4:0] s);
    logic [47:0] m;
    case (s)
      5'd1:    m = 48'((64'd1 << 48) / 64'd2);
      5'd2:    m = 48'((64'd1 << 48) / 64'd3);
      5'd3:    m = 48'((64'd1 << 48) / 64'd7);
      5'd4:    m = 48'((64'd1 << 48) / 64'd13);
      5'd5:    m = 48'((64'd1 << 48) / 64'd31);
      5'd6:    m = 48'((64'd1 << 48) / 64'd61);
      5'd7:    m = 48'((64'd1 << 48) / 64'd127);
      5'd8:    m = 48'((64'd1 << 48) / 64'd251);
      5'd9:    m = 48'((64'd1 << 48) / 64'd509);
      5'd10:   m = 48'((64'd1 << 48) / 64'd1021);
      5'd11:   m = 48'((64'd1 << 48) / 64'd2039);
      5'd12:   m = 48'((64'd1 << 48) / 64'd4093);
      5'd13:   m = 48'((64'd1 << 48) / 64'd8191);
      5'd14:   m = 48'((64'd1 << 48) / 64'd16381);
      5'd15:   m = 48'((64'd1 << 48) / 64'd32749);
      5'd16:   m = 48'((64'd1 << 48) / 64'd65521);
      default: m = 48'hFFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/oaht_ctrl.sv @@
// ----------------------------------------------------------------------------
// oaht_ctrl: sequencing controller
// Steps each request through modulo, probe and write-back; runs clear sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  oaht_pkg::sts_t     sts,
  output oaht_pkg::ctl_t     ctl
);
  import oaht_pkg::*;

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_INIT  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_EVAL  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       item_r, item_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    ctl       = '0;
    case (state_r)
      S_SWEEP: begin
        ctl.sweep_adv = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = item_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          if (sts.new_clear) begin
            ctl.sweep_init = 1'b1;
            item_nxt       = 1'b1;
            state_nxt      = S_SWEEP;
          end else begin
            ctl.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        ctl.probe_init = 1'b1;
        state_nxt      = S_READ;
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        ctl.probe_eval = 1'b1;
        if (sts.slot_unused || sts.slot_match || sts.probe_last) begin
          ctl.eval_end = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          ctl.probe_adv = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          ctl.fin   = 1'b1;
          item_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      item_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      item_r  <= item_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/oaht_dp.sv @@
// ----------------------------------------------------------------------------
// oaht_dp: datapath
// Slot memory, reciprocal modulo unit, probe registers, counts and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_dp #(
  parameter int MAX_SHIFT = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [31:0]                   in_key,
  input  wire logic [31:0]                   in_value,
  input  wire logic                          cfg_wr_en,
  input  wire logic [oaht_pkg::SHIFT_W-1:0]  cfg_wr_data,
  input  oaht_pkg::ctl_t                     ctl,
  output oaht_pkg::sts_t                     sts,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [31:0]                        out_value_out,
  output logic [1:0]                         out_status,
  output logic [oaht_pkg::COUNT_W-1:0]       out_live_count
);
  import oaht_pkg::*;

  localparam int AW    = MAX_SHIFT;
  localparam int DEPTH = 1 << AW;

  slot_t mem [DEPTH];
  slot_t rd_r;

  logic [1:0]         cmd_r;
  logic [31:0]        key_r, val_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [4:0]         eff;
  logic [AW-1:0]      mask;
  logic [AW:0]        prime;
  logic [47:0]        recip;
  logic [15:0]        rcp_part;
  logic [47:0]        part_prod;
  logic [31:0]        q_prod;
  logic [31:0]        num_r;
  logic [79:0]        acc_r;
  logic [AW:0]        rem_r;
  logic [2:0]         div_cnt_r;
  logic [AW-1:0]      idx_r, step_r, n_r, tomb_r, tgt_r, sweep_r;
  logic               have_tomb_r, hit_r, free_r;
  logic               tomb_now;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               we;
  logic [AW-1:0]      waddr;
  slot_t              wdata;
  logic               res_found;
  logic [31:0]        res_value;
  logic [1:0]         res_status;
  logic               out_valid_r, out_found_r;
  logic [31:0]        out_value_r;
  logic [1:0]         out_status_r;
  logic [COUNT_W-1:0] out_count_r;

  always_comb begin
    if (shift_r < SHIFT_W'(MIN_SHIFT)) begin
      eff = 5'(MIN_SHIFT);
    end else if (32'(shift_r) > MAX_SHIFT) begin
      eff = 5'(MAX_SHIFT);
    end else begin
      eff = 5'(shift_r);
    end
  end

  assign mask  = ~({AW{1'b1}} << eff);
  assign prime = (AW+1)'(prime_of(eff));
  assign recip = recip_of(eff);

  assign rcp_part  = (div_cnt_r == 3'd0) ? recip[15:0] :
                     (div_cnt_r == 3'd1) ? recip[31:16] : recip[47:32];
  assign part_prod = 48'(num_r) * 48'(rcp_part);
  assign q_prod    = acc_r[79:48] * 32'(prime);

  assign tomb_now = (rd_r.state == SLOT_TOMB);

  assign sts.new_clear   = (in_cmd == CMD_CLEAR);
  assign sts.div_last    = (div_cnt_r == 3'd4);
  assign sts.slot_unused = (rd_r.state == SLOT_UNUSED);
  assign sts.slot_match  = (rd_r.state == SLOT_LIVE) && (rd_r.key == key_r);
  assign sts.probe_last  = (n_r == mask);
  assign sts.sweep_last  = &sweep_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  // write-back and result
  always_comb begin
    we         = 1'b0;
    waddr      = idx_r;
    wdata      = '0;
    count_nxt  = count_r;
    res_found  = 1'b0;
    res_value  = 32'd0;
    res_status = ST_DONE;
    if (ctl.sweep_adv) begin
      we    = 1'b1;
      waddr = sweep_r;
    end else if (ctl.fin) begin
      case (cmd_r)
        CMD_LOOKUP: begin
          if (hit_r) begin
            res_found = 1'b1;
            res_value = rd_r.value;
          end else begin
            res_status = ST_MISS;
          end
        end
        CMD_INSERT: begin
          wdata = '{state: SLOT_LIVE, key: key_r, value: val_r};
          if (hit_r) begin
            res_found = 1'b1;
            we        = 1'b1;
          end else if (free_r) begin
            we        = 1'b1;
            waddr     = tgt_r;
            count_nxt = count_r + COUNT_W'(1);
          end else begin
            res_status = ST_FULL;
          end
        end
        CMD_REMOVE: begin
          wdata = '{state: SLOT_TOMB, key: 32'd0, value: 32'd0};
          if (hit_r) begin
            res_found = 1'b1;
            we        = 1'b1;
            count_nxt = count_r - COUNT_W'(1);
          end else begin
            res_status = ST_MISS;
          end
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= SHIFT_W'(MIN_SHIFT);
      sweep_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        shift_r <= cfg_wr_data;
      end
      if (ctl.sweep_init) begin
        sweep_r <= '0;
        count_r <= '0;
      end else if (ctl.sweep_adv) begin
        sweep_r <= sweep_r + AW'(1);
      end else begin
        count_r <= count_nxt;
      end
      if (ctl.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (ctl.div_start) begin
      num_r     <= (in_key < 32'd2) ? 32'd2 : in_key;
      acc_r     <= '0;
      div_cnt_r <= '0;
    end else if (ctl.div_step) begin
      case (div_cnt_r)
        3'd0:    acc_r <= acc_r + {32'd0, part_prod};
        3'd1:    acc_r <= acc_r + {16'd0, part_prod, 16'd0};
        3'd2:    acc_r <= acc_r + {part_prod, 32'd0};
        3'd3:    rem_r <= (AW+1)'(num_r - q_prod);
        default: rem_r <= (rem_r >= prime) ? rem_r - prime : rem_r;
      endcase
      div_cnt_r <= div_cnt_r + 3'd1;
    end
    if (ctl.probe_init) begin
      idx_r       <= rem_r[AW-1:0] & mask;
      step_r      <= '0;
      n_r         <= '0;
      have_tomb_r <= 1'b0;
    end else begin
      if (ctl.probe_eval && tomb_now && !have_tomb_r) begin
        have_tomb_r <= 1'b1;
        tomb_r      <= idx_r;
      end
      if (ctl.probe_adv) begin
        step_r <= step_r + AW'(1);
        idx_r  <= (idx_r + step_r + AW'(1)) & mask;
        n_r    <= n_r + AW'(1);
      end
    end
    if (ctl.eval_end) begin
      hit_r  <= sts.slot_match;
      free_r <= sts.slot_unused || have_tomb_r || tomb_now;
      tgt_r  <= have_tomb_r ? tomb_r : idx_r;
    end
    if (ctl.fin) begin
      out_found_r  <= res_found;
      out_value_r  <= res_value;
      out_status_r <= res_status;
      out_count_r  <= (cmd_r == CMD_CLEAR) ? '0 : count_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_value_out  = out_value_r;
  assign out_status     = out_status_r;
  assign out_live_count = out_count_r;

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fin |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fin && res_status == ST_FULL) |-> (cmd_r == CMD_INSERT))
    else $error("table full reported for a non-insert request");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fin && res_found) |=> (out_status == ST_DONE))
    else $error("hit reported with a failing status");

endmodule

`default_nettype wire

@@ hw/rtl/open_addressing_hash_table_unit.sv @@
// Lookup, insert and remove pass a reciprocal modulo step, then a read and an evaluate
// per probe, then write-back; a new request is taken only once the controller is idle again.
// Clear: sweeps the slots, one slot per cycle through the memory port.
// An untaken result holds the controller. Reset: synchronous, active low; a clearing
// pass over every slot follows, with no request accepted until it ends
// (configuration writes still taken).
// ----------------------------------------------------------------------------
// open_addressing_hash_table_unit: key/value table top level
// Quadratic-probe table with tombstones; controller plus datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_table_unit #(
  parameter int MAX_SHIFT = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [31:0]                   in_key,
  input  wire logic [31:0]                   in_value,
  input  wire logic                          cfg_wr_en,
  input  wire logic [oaht_pkg::SHIFT_W-1:0]  cfg_wr_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic [31:0]                        out_value_out,
  output logic [1:0]                         out_status,
  output logic [oaht_pkg::COUNT_W-1:0]       out_live_count
);
  import oaht_pkg::*;

  ctl_t ctl;
  sts_t sts;

  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  oaht_dp #(
    .MAX_SHIFT (MAX_SHIFT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_cmd),
    .in_key         (in_key),
    .in_value       (in_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .ctl            (ctl),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_value_out  (out_value_out),
    .out_status     (out_status),
    .out_live_count (out_live_count)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: open_addressing_hash_table_unit regression
// Drives lookup, insert, remove and clear requests through a directed table and
// then randomised phases over several table sizes and idle patterns; each
// response is checked against a set value or a behavioural table model here.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import oaht_pkg::*;

  localparam int  NSLOTS      = 1024;
  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  NPHASES     = 8;
  localparam int  PHASE_REQS  = 80;

  typedef struct packed {
    logic        found;
    logic [31:0] value;
    logic [1:0]  status;
    logic [10:0] live;
  } resp_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] value;
    bit          known;
    resp_t       resp;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = CMD_LOOKUP;
  logic [31:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_found;
  logic [31:0] out_value_out;
  logic [1:0]  out_status;
  logic [10:0] out_live_count;

  logic [31:0] tbl_tag [NSLOTS];
  logic [31:0] tbl_key [NSLOTS];
  logic [31:0] tbl_val [NSLOTS];
  logic [10:0] live_cnt;
  logic [3:0]  shift_reg;

  resp_t       pending_resp[$];
  int          errors = 0;
  int          cycles = 0;
  int          sent = 0;
  int          checked = 0;
  int          snd_pct = 0;
  int          rcv_pct = 0;

  open_addressing_hash_table_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_key(in_key), .in_value(in_value),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_found(out_found), .out_value_out(out_value_out),
    .out_status(out_status), .out_live_count(out_live_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int prime_for(input int s);
    case (s)
      3: return 7;
      4: return 13;
      5: return 31;
      6: return 61;
      7: return 127;
      8: return 251;
      9: return 509;
      default: return 1021;
    endcase
  endfunction

  task automatic table_clear();
    for (int i = 0; i < NSLOTS; i++) begin
      tbl_tag[i] = '0;
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    live_cnt = '0;
  endtask

  task automatic table_apply(input logic [1:0] cmd, input logic [31:0] key,
                             input logic [31:0] val, output resp_t r);
    int          s;
    int          tsize;
    logic [31:0] hash;
    logic [31:0] idx;
    logic [31:0] step;
    bit          hit;
    bit          have_tomb;
    bit          free_ok;
    logic [31:0] tomb;
    logic [31:0] slot;
    r = '0;
    s = (shift_reg < MIN_SHIFT) ? MIN_SHIFT : (shift_reg > 10) ? 10 : shift_reg;
    tsize = 1 << s;
    hash = (key < 2) ? 32'd2 : key;
    if (cmd == CMD_CLEAR) begin
      table_clear();
    end else begin
      idx = (hash % prime_for(s)) & (tsize - 1);
      step = 0;
      hit = 0;
      have_tomb = 0;
      free_ok = 0;
      tomb = 0;
      slot = 0;
      for (int n = 0; n < tsize; n++) begin
        if (tbl_tag[idx] == 0) begin
          free_ok = 1;
          slot = have_tomb ? tomb : idx;
          break;
        end
        if (tbl_tag[idx] == hash && tbl_key[idx] == key) begin
          hit = 1;
          slot = idx;
          break;
        end
        if (tbl_tag[idx] == 1 && !have_tomb) begin
          have_tomb = 1;
          tomb = idx;
        end
        step++;
        idx = (idx + step) & (tsize - 1);
      end
      if (!hit && !free_ok && have_tomb) begin
        free_ok = 1;
        slot = tomb;
      end
      case (cmd)
        CMD_LOOKUP: begin
          if (hit) begin
            r.found = 1'b1;
            r.value = tbl_val[slot];
          end else r.status = ST_MISS;
        end
        CMD_INSERT: begin
          if (hit) begin
            r.found = 1'b1;
            tbl_val[slot] = val;
          end else if (free_ok) begin
            tbl_tag[slot] = hash;
            tbl_key[slot] = key;
            tbl_val[slot] = val;
            live_cnt = live_cnt + 11'd1;
          end else r.status = ST_FULL;
        end
        default: begin
          if (hit) begin
            r.found = 1'b1;
            tbl_tag[slot] = 1;
            tbl_key[slot] = 0;
            tbl_val[slot] = 0;
            live_cnt = live_cnt - 11'd1;
          end else r.status = ST_MISS;
        end
      endcase
    end
    r.live = live_cnt;
  endtask

  task automatic issue(input logic [1:0] cmd, input logic [31:0] key,
                       input logic [31:0] val, input bit known, input resp_t kr);
    resp_t r;
    while (snd_pct > 0 && $urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
    table_apply(cmd, key, val, r);
    pending_resp.push_back(known ? kr : r);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_shift(input logic [3:0] s);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shift_reg = s;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("open_addressing_hash_table_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_pct);
  end

  always @(posedge clk) begin
    resp_t got;
    resp_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_found, out_value_out, out_status, out_live_count};
      if (pending_resp.size() == 0) begin
        $display("%0t: unexpected response %p", $realtime, got);
        errors++;
      end else begin
        want = pending_resp.pop_front();
        checked++;
        if (got.found !== want.found)
          $display("%0t: found exp %0d got %0d", $realtime, want.found, got.found);
        if (got.value !== want.value)
          $display("%0t: value exp %h got %h", $realtime, want.value, got.value);
        if (got.status !== want.status)
          $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
        if (got.live !== want.live)
          $display("%0t: live exp %0d got %0d", $realtime, want.live, got.live);
        if (got !== want) errors++;
      end
    end
  end

  row_t        rows[$];
  logic [31:0] key_pool[];
  logic [3:0]  phase_shift[NPHASES] = '{4'd15, 4'd10, 4'd4, 4'd0, 4'd7, 4'd3, 4'd9, 4'd5};

  function automatic row_t mk(input logic [1:0] c, input logic [31:0] k,
                              input logic [31:0] v, input bit kn, input resp_t r);
    row_t t;
    t.cmd = c; t.key = k; t.value = v; t.known = kn; t.resp = r;
    return t;
  endfunction

  initial begin
    int          pool_n;
    int          sel;
    logic [1:0]  c;
    logic [31:0] k;
    table_clear();
    shift_reg = 4'd3;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    rows.push_back(mk(CMD_LOOKUP, 32'd0, 32'd0, 1, '{1'b0, 32'd0, ST_MISS, 11'd0}));
    rows.push_back(mk(CMD_INSERT, 32'd0, 32'hFFFFFFFF, 1, '{1'b0, 32'd0, ST_DONE, 11'd1}));
    rows.push_back(mk(CMD_INSERT, 32'd1, 32'd0, 1, '{1'b0, 32'd0, ST_DONE, 11'd2}));
    rows.push_back(mk(CMD_LOOKUP, 32'd0, 32'd0, 1, '{1'b1, 32'hFFFFFFFF, ST_DONE, 11'd2}));
    rows.push_back(mk(CMD_LOOKUP, 32'd1, 32'd5, 1, '{1'b1, 32'd0, ST_DONE, 11'd2}));
    rows.push_back(mk(CMD_INSERT, 32'd0, 32'h5A5A5A5A, 1, '{1'b1, 32'd0, ST_DONE, 11'd2}));
    rows.push_back(mk(CMD_LOOKUP, 32'd0, 32'd0, 0, '0));
    rows.push_back(mk(CMD_REMOVE, 32'd0, 32'd0, 1, '{1'b1, 32'd0, ST_DONE, 11'd1}));
    rows.push_back(mk(CMD_REMOVE, 32'd0, 32'd0, 1, '{1'b0, 32'd0, ST_MISS, 11'd1}));
    rows.push_back(mk(CMD_INSERT, 32'hFFFFFFFF, 32'hA5A5A5A5, 0, '0));
    rows.push_back(mk(CMD_LOOKUP, 32'hFFFFFFFF, 32'd0, 0, '0));
    rows.push_back(mk(CMD_INSERT, 32'd2, 32'd2, 0, '0));
    rows.push_back(mk(CMD_CLEAR, 32'd0, 32'd0, 1, '{1'b0, 32'd0, ST_DONE, 11'd0}));
    for (int i = 0; i < 8; i++)
      rows.push_back(mk(CMD_INSERT, 32'd7 * i + 3, 32'h100 + i, 0, '0));
    rows.push_back(mk(CMD_INSERT, 32'd999, 32'd1, 1, '{1'b0, 32'd0, ST_FULL, 11'd8}));
    rows.push_back(mk(CMD_REMOVE, 32'd10, 32'd0, 0, '0));
    rows.push_back(mk(CMD_INSERT, 32'd999, 32'd1, 0, '0));
    rows.push_back(mk(CMD_LOOKUP, 32'd999, 32'd0, 0, '0));

    foreach (rows[i]) issue(rows[i].cmd, rows[i].key, rows[i].value, rows[i].known,
                            rows[i].resp);

    for (int p = 0; p < NPHASES; p++) begin
      write_shift(phase_shift[p]);
      case (p % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 68; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 68; end
        default: begin snd_pct = 33; rcv_pct = 33; end
      endcase
      pool_n = (phase_shift[p] > 6 || phase_shift[p] < 3) ? 48 :
               (3 << phase_shift[p]) / 2;
      key_pool = new[pool_n];
      foreach (key_pool[i])
        key_pool[i] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(4095);
      for (int n = 0; n < PHASE_REQS; n++) begin
        sel = $urandom_range(99);
        c = (sel < 3) ? CMD_CLEAR : (sel < 45) ? CMD_INSERT :
            (sel < 75) ? CMD_LOOKUP : CMD_REMOVE;
        sel = $urandom_range(99);
        k = (sel < 75) ? key_pool[$urandom_range(pool_n - 1)] :
            (sel < 80) ? {31'd0, 1'($urandom_range(1))} : $urandom;
        issue(c, k, $urandom, 0, '0);
      end
    end

    snd_pct = 0;
    rcv_pct = 0;
    drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d requests over %0d randomised phases, %0d responses checked.",
             sent, NPHASES, checked);
    if (errors == 0 && pending_resp.size() == 0)
      $display("open_addressing_hash_table_unit regression: pass");
    else
      $display("open_addressing_hash_table_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
